// File: design/lzwc_pkg.sv
package lzwc_pkg;

   localparam int DICT_ENTRIES    = 4096;
   localparam int HASH_SLOTS      = 8192;
   localparam int FIRST_FREE_CODE = 256;

   localparam int CODE_BITS  = 12;
   localparam int BYTE_BITS  = 8;
   localparam int KEY_BITS   = CODE_BITS + BYTE_BITS;
   localparam int FREE_BITS  = CODE_BITS + 1;
   localparam int SLOT_BITS  = $clog2(HASH_SLOTS);
   localparam int EPOCH_BITS = 8;
   localparam int CODE_SPACE = 1 << CODE_BITS;
   localparam int CODE_LIMIT = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = ((CODE_BITS + 7) / 8) * 8;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   typedef logic [CODE_BITS-1:0]  code_type;
   typedef logic [BYTE_BITS-1:0]  byte_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [FREE_BITS-1:0]  free_type;
   typedef logic [EPOCH_BITS-1:0] epoch_type;

   // an entry is live only when its epoch matches the current stream's epoch
   typedef struct packed {
      epoch_type epoch;
      key_type   key;
      code_type  code;
   } entry_type;

   typedef struct packed {
      code_type code;
      logic     final_code;
   } code_item_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ISSUE,
      S_CHECK,
      S_FINAL
   } state_type;

   function automatic slot_type slot_of(input key_type key);
      logic [31:0] k32;
      logic [31:0] h;
      k32 = 32'(key);
      h   = (k32 * HASH_MULT) ^ (k32 >> 7);
      return h[SLOT_BITS-1:0];
   endfunction

endpackage

// File: design/lzwc_out_fifo.sv
module lzwc_out_fifo (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   input  lzwc_pkg::code_item_type                push_item,
   output logic                                   full,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [11:0] code, [15:12] zero
   output logic [lzwc_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                   rsp_tlast
);
   import lzwc_pkg::*;

   code_item_type entries_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          pop;
   code_item_type head;

   assign pop        = rsp_tvalid && rsp_tready;
   assign full       = (count_ff == 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign head       = entries_ff[rd_ptr_ff];
   assign rsp_tdata  = RSP_DATA_BITS'(head.code);
   assign rsp_tlast  = head.final_code;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: design/lzw_compressor.sv
// LZW compressor, 12-bit codes.
// Input channel req_*: one byte per transfer in tdata[7:0], tlast marks the
// last byte of a stream. Result channel rsp_*: one code per transfer in
// tdata[11:0], tlast set on the final code of a stream.
// The dictionary lives in an 8192-slot hash table in one synchronous RAM,
// probed linearly, each probe a RAM read and then a compare.
// A byte passes through accept, RAM read and compare/insert, with another
// read and compare for each extra probe after a collision and a final flush
// on a last byte. A new byte is taken only once the last one is through, and
// a full queue holds compare/insert and the flush. The first byte of a stream
// is only accepted, and flushed if it is also the last. A miss code enters
// the output queue from compare/insert and shows on rsp_* right after the push.
// Slots are tagged with an 8-bit stream epoch, so ending a stream clears the
// dictionary at once. After reset, and after every 255th stream when the epoch
// wraps, a sweep rewrites all 8192 slots; req_tready stays low during it.
// Results wait in a two-entry queue; while rsp_tready is low the block keeps
// taking bytes until it needs to emit into a full queue, then holds.
module lzw_compressor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] data_byte
   input  logic [lzwc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] code, [15:12] zero
   output logic [lzwc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);
   import lzwc_pkg::*;

   state_type     state_ff, state_in;
   byte_type      byte_ff, byte_in;
   logic          last_ff, last_in;
   code_type      prefix_ff, prefix_in;
   logic          held_ff, held_in;
   free_type      next_free_ff, next_free_in;
   epoch_type     epoch_ff, epoch_in;
   slot_type      probe_idx_ff, probe_idx_in;
   slot_type      probe_cnt_ff, probe_cnt_in;
   slot_type      clr_idx_ff, clr_idx_in;

   entry_type     hash_mem [HASH_SLOTS];
   entry_type     rd_ff;
   logic          mem_re;
   logic          mem_we;
   slot_type      mem_waddr;
   entry_type     mem_wdata;

   logic          fifo_push;
   logic          fifo_full;
   code_item_type fifo_item;

   logic          req_xfer;
   key_type       key;
   logic          slot_live;
   logic          hit;
   logic          give_up;
   logic          can_add;

   assign req_xfer  = req_tvalid && req_tready;
   assign key       = {prefix_ff, byte_ff};
   assign slot_live = (rd_ff.epoch == epoch_ff);
   assign hit       = slot_live && (rd_ff.key == key);
   assign give_up   = slot_live && !hit && (probe_cnt_ff == SLOT_BITS'(HASH_SLOTS - 1));
   assign can_add   = !slot_live && (next_free_ff < FREE_BITS'(CODE_LIMIT));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hash_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= hash_mem[probe_idx_ff];
      end
   end

   lzwc_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (fifo_push),
      .push_item  (fifo_item),
      .full       (fifo_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == SLOT_BITS'(HASH_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               if (held_ff) begin
                  state_in = S_ISSUE;
               end else if (req_tlast) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_ISSUE: state_in = S_CHECK;
         S_CHECK: begin
            priority if (hit) begin
               state_in = last_ff ? S_FINAL : S_IDLE;
            end else if (!slot_live || give_up) begin
               if (!fifo_full) begin
                  state_in = last_ff ? S_FINAL : S_IDLE;
               end
            end else begin
               state_in = S_ISSUE;
            end
         end
         S_FINAL: begin
            if (!fifo_full) begin
               state_in = (epoch_ff == '1) ? S_CLEAR : S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      byte_in      = byte_ff;
      last_in      = last_ff;
      prefix_in    = prefix_ff;
      held_in      = held_ff;
      next_free_in = next_free_ff;
      epoch_in     = epoch_ff;
      probe_idx_in = probe_idx_ff;
      probe_cnt_in = probe_cnt_ff;
      clr_idx_in   = clr_idx_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = probe_idx_ff;
      mem_wdata    = '{epoch: epoch_ff, key: key, code: next_free_ff[CODE_BITS-1:0]};
      fifo_push    = 1'b0;
      fifo_item    = '{code: prefix_ff, final_code: 1'b0};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_xfer) begin
               byte_in      = req_tdata[BYTE_BITS-1:0];
               last_in      = req_tlast;
               probe_idx_in = slot_of({prefix_ff, req_tdata[BYTE_BITS-1:0]});
               probe_cnt_in = '0;
               if (!held_ff) begin
                  prefix_in = CODE_BITS'(req_tdata[BYTE_BITS-1:0]);
                  held_in   = 1'b1;
               end
            end
         end
         S_ISSUE: mem_re = 1'b1;
         S_CHECK: begin
            priority if (hit) begin
               prefix_in = rd_ff.code;
            end else if (!slot_live || give_up) begin
               if (!fifo_full) begin
                  fifo_push = 1'b1;
                  prefix_in = CODE_BITS'(byte_ff);
                  if (can_add) begin
                     mem_we       = 1'b1;
                     next_free_in = next_free_ff + 1'b1;
                  end
               end
            end else begin
               probe_idx_in = probe_idx_ff + 1'b1;
               probe_cnt_in = probe_cnt_ff + 1'b1;
            end
         end
         S_FINAL: begin
            fifo_item = '{code: prefix_ff, final_code: 1'b1};
            if (!fifo_full) begin
               fifo_push    = 1'b1;
               prefix_in    = '0;
               held_in      = 1'b0;
               next_free_in = FREE_BITS'(FIRST_FREE_CODE);
               epoch_in     = (epoch_ff == '1) ? EPOCH_BITS'(1) : epoch_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      probe_idx_ff <= probe_idx_in;
      probe_cnt_ff <= probe_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         prefix_ff    <= '0;
         held_ff      <= 1'b0;
         next_free_ff <= FREE_BITS'(FIRST_FREE_CODE);
         epoch_ff     <= EPOCH_BITS'(1);
         clr_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         held_ff      <= held_in;
         next_free_ff <= next_free_in;
         epoch_ff     <= epoch_in;
         clr_idx_ff   <= clr_idx_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full)
      else $error("result pushed into full queue");

   a_code_limit: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FREE_BITS'(CODE_LIMIT))
      else $error("free code past limit");

   a_insert_empty: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == S_CHECK) |-> !slot_live)
      else $error("insert over live slot");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("epoch matches swept slots");

   a_flush_ends_stream: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL && !fifo_full) |=> (!held_ff && next_free_ff ==
         FREE_BITS'(FIRST_FREE_CODE)))
      else $error("stream state not cleared after flush");

endmodule
